>>> sv/alb_pkg.sv
// ---------------------------------------------------------------------------
// alb_pkg
// shared constants for the ambient light brightness control block
// ---------------------------------------------------------------------------
package alb_pkg;

	// configuration channel layout
	localparam int CFG_INDEX_BITS = 4;
	localparam int CFG_DATA_BITS  = 16;
	localparam int LEVEL_BITS     = 8;

	typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
	typedef logic [LEVEL_BITS-1:0]     level_t;

	// register indexes
	localparam cfg_index_t REG_SENSOR_DARK   = 4'd0;
	localparam cfg_index_t REG_SENSOR_BRIGHT = 4'd1;
	localparam cfg_index_t REG_LEVEL_DARK    = 4'd2;
	localparam cfg_index_t REG_LEVEL_BRIGHT  = 4'd3;

	// reset values, sensor limits given at the widest sample size
	localparam logic [CFG_DATA_BITS-1:0] RST_SENSOR_DARK   = 16'd20;
	localparam logic [CFG_DATA_BITS-1:0] RST_SENSOR_BRIGHT = 16'd950;
	localparam level_t                   RST_LEVEL_DARK    = 8'd15;
	localparam level_t                   RST_LEVEL_BRIGHT  = 8'd255;
	localparam level_t                   LEVEL_MAX         = 8'd255;

endpackage

>>> sv/alb_if.sv
// ---------------------------------------------------------------------------
// alb_if
// handshake channels: sample stream, result stream, configuration writes
// ---------------------------------------------------------------------------
interface alb_stream_if #(parameter int W = 10);
	logic         valid;
	logic         ready;
	logic [W-1:0] light_sample;
	modport source (output valid, output light_sample, input ready);
	modport sink   (input valid, input light_sample, output ready);
endinterface

interface alb_result_if #(parameter int W = 10);
	logic         valid;
	logic         ready;
	logic [7:0]   brightness;
	logic [W-1:0] median_light;
	logic         level_changed;
	modport source (output valid, output brightness, output median_light,
		output level_changed, input ready);
	modport sink   (input valid, input brightness, input median_light,
		input level_changed, output ready);
endinterface

interface alb_cfg_if;
	logic        valid;
	logic        ready;
	logic [3:0]  index;
	logic [15:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/alb_front.sv
// ---------------------------------------------------------------------------
// alb_front
// clamps incoming samples to the sensor limits and queues them
// ---------------------------------------------------------------------------
module alb_front #(
	parameter int SAMPLE_BITS = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [SAMPLE_BITS-1:0] dark_limit,
	input  logic [SAMPLE_BITS-1:0] bright_limit,
	alb_stream_if.sink             smp,
	alb_stream_if.source           q
);
	logic [SAMPLE_BITS-1:0] clamped;
	logic [SAMPLE_BITS-1:0] slot_q [2];
	logic                   wr_ptr_q;
	logic                   rd_ptr_q;
	logic [1:0]             count_q;
	logic                   push;
	logic                   pop;

	// dark limit tested first
	always_comb begin
		priority if (smp.light_sample < dark_limit) clamped = dark_limit;
		else if (smp.light_sample > bright_limit) clamped = bright_limit;
		else clamped = smp.light_sample;
	end

	assign smp.ready      = (count_q != 2'd2);
	assign q.valid        = (count_q != 2'd0);
	assign q.light_sample = slot_q[rd_ptr_q];
	assign push           = smp.valid & smp.ready;
	assign pop            = q.valid & q.ready;

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= clamped;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

>>> sv/alb_back.sv
// ---------------------------------------------------------------------------
// alb_back
// window update, running median, linear map and dead-band update
// ---------------------------------------------------------------------------
module alb_back #(
	parameter int WINDOW      = 10,
	parameter int SAMPLE_BITS = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [SAMPLE_BITS-1:0] dark_limit,
	input  logic [SAMPLE_BITS-1:0] bright_limit,
	input  alb_pkg::level_t        level_dark,
	input  alb_pkg::level_t        level_bright,
	alb_stream_if.sink             q,
	alb_result_if.source           res
);
	import alb_pkg::*;

	localparam int SB  = SAMPLE_BITS;
	localparam int IW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CW  = $clog2(WINDOW + 1);
	localparam int NB  = ((SB + 9) / 2) * 2;
	localparam int DIT = NB / 2;
	localparam int DCW = $clog2(DIT + 1);
	localparam int PW  = SB + 10;
	localparam int TW  = NB + 2;
	localparam logic [CW-1:0]  WIN_C = CW'(WINDOW);
	localparam logic [IW-1:0]  LAST_SLOT = IW'(WINDOW - 1);
	localparam logic [DCW-1:0] DIT_C = DCW'(DIT);

	typedef enum logic [2:0] {
		S_IDLE, S_DEL, S_INS, S_MED0, S_MED1, S_MUL, S_DIV, S_FIN
	} state_t;

	state_t          state_q;
	logic [SB-1:0]   ring_q   [WINDOW];
	logic [SB-1:0]   sorted_q [WINDOW];
	logic [SB-1:0]   sorted_nx[WINDOW];
	logic [IW-1:0]   slot_q;
	logic [CW-1:0]   cnt_q;
	logic [SB-1:0]   s_q;
	logic [SB-1:0]   lo_q;
	logic [SB-1:0]   med_q;
	logic [NB-1:0]   num_q;
	logic [SB-1:0]   rem_q;
	logic [SB-1:0]   den_q;
	logic            neg_q;
	logic            eq_q;
	logic [DCW-1:0]  dcnt_q;
	level_t          level_q;
	logic            out_valid_q;
	level_t          out_bright_q;
	logic [SB-1:0]   out_med_q;
	logic            out_chg_q;

	logic [SB-1:0]   old_v;
	logic [IW-1:0]   rd_idx;
	logic [SB-1:0]   rd_val;
	logic [CW-1:0]   cm1;
	logic            ins_gt [WINDOW];
	logic            out_load;

	assign old_v = ring_q[slot_q];
	assign cm1   = cnt_q - CW'(1);
	assign rd_idx = (state_q == S_MED0) ? IW'(cm1 >> 1) : IW'(cnt_q >> 1);
	assign rd_val = sorted_q[rd_idx];

	// delete shifts cells at or above the oldest value down; insert opens a gap
	always_comb begin
		for (int k = 0; k < WINDOW; k++) begin
			ins_gt[k] = (CW'(k) >= cnt_q) || (sorted_q[k] > s_q);
		end
		for (int k = 0; k < WINDOW; k++) begin
			sorted_nx[k] = sorted_q[k];
			if (state_q == S_DEL) begin
				if ((CW'(k) < cnt_q) && (sorted_q[k] >= old_v) && (k + 1 < WINDOW))
					sorted_nx[k] = sorted_q[(k + 1 < WINDOW) ? k + 1 : k];
			end else if (ins_gt[k]) begin
				if (k > 0 && ins_gt[(k > 0) ? k - 1 : 0])
					sorted_nx[k] = sorted_q[(k > 0) ? k - 1 : 0];
				else
					sorted_nx[k] = s_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DEL || state_q == S_INS) sorted_q <= sorted_nx;
		if (state_q == S_INS) ring_q[slot_q] <= s_q;
	end

	// map arithmetic
	logic signed [SB:0]   dmed;
	logic signed [8:0]    dlev;
	logic signed [PW-1:0] prod;
	logic signed [SB:0]   dden;
	logic [PW-1:0]        prod_mag;
	logic [SB:0]          den_mag;
	logic [SB:0]          r1, r2;
	logic [SB-1:0]        r1n, r2n;
	logic                 qb1, qb2;
	logic signed [TW-1:0] qs, tgt;
	level_t               target;
	level_t               diff;

	assign dmed = $signed({1'b0, med_q}) - $signed({1'b0, dark_limit});
	assign dlev = $signed({1'b0, level_bright}) - $signed({1'b0, level_dark});
	assign dden = $signed({1'b0, bright_limit}) - $signed({1'b0, dark_limit});
	assign prod = PW'(dmed) * PW'(dlev);
	assign prod_mag = prod[PW-1] ? PW'(-prod) : PW'(prod);
	assign den_mag  = dden[SB] ? (SB+1)'(-dden) : (SB+1)'(dden);

	// two restoring division steps per cycle
	always_comb begin
		r1  = {rem_q, num_q[NB-1]};
		qb1 = r1 >= {1'b0, den_q};
		r1n = qb1 ? SB'(r1 - {1'b0, den_q}) : r1[SB-1:0];
		r2  = {r1n, num_q[NB-2]};
		qb2 = r2 >= {1'b0, den_q};
		r2n = qb2 ? SB'(r2 - {1'b0, den_q}) : r2[SB-1:0];
	end

	always_comb begin
		qs  = neg_q ? -$signed({2'b00, num_q}) : $signed({2'b00, num_q});
		tgt = qs + $signed(TW'(level_dark));
		if (eq_q) target = level_dark;
		else if (tgt < 0) target = '0;
		else if (tgt > $signed(TW'(LEVEL_MAX))) target = LEVEL_MAX;
		else target = tgt[LEVEL_BITS-1:0];
		diff = (target > level_q) ? target - level_q : level_q - target;
	end

	assign out_load          = (state_q == S_FIN) && (!out_valid_q || res.ready);
	assign q.ready           = (state_q == S_IDLE);
	assign res.valid         = out_valid_q;
	assign res.brightness    = out_bright_q;
	assign res.median_light  = out_med_q;
	assign res.level_changed = out_chg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			slot_q      <= '0;
			cnt_q       <= '0;
			level_q     <= '0;
			out_valid_q <= 1'b0;
			dcnt_q      <= '0;
		end else begin
			if (out_load) out_valid_q <= 1'b1;
			else if (res.valid && res.ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (q.valid) begin
						s_q     <= q.light_sample;
						state_q <= (cnt_q == WIN_C) ? S_DEL : S_INS;
					end
				end
				S_DEL: begin
					cnt_q   <= cm1;
					state_q <= S_INS;
				end
				S_INS: begin
					cnt_q   <= cnt_q + CW'(1);
					slot_q  <= (slot_q == LAST_SLOT) ? '0 : slot_q + IW'(1);
					state_q <= S_MED0;
				end
				S_MED0: begin
					lo_q    <= rd_val;
					state_q <= S_MED1;
				end
				S_MED1: begin
					med_q   <= SB'(({1'b0, lo_q} + {1'b0, rd_val}) >> 1);
					state_q <= S_MUL;
				end
				S_MUL: begin
					num_q   <= prod_mag[NB-1:0];
					den_q   <= den_mag[SB-1:0];
					rem_q   <= '0;
					neg_q   <= prod[PW-1] ^ dden[SB];
					eq_q    <= (dden == '0);
					dcnt_q  <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					num_q  <= {num_q[NB-3:0], qb1, qb2};
					rem_q  <= r2n;
					dcnt_q <= dcnt_q + DCW'(1);
					if (dcnt_q == DIT_C - DCW'(1)) state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_load) begin
						out_med_q    <= med_q;
						out_chg_q    <= (diff > 8'd1);
						out_bright_q <= (diff > 8'd1) ? target : level_q;
						if (diff > 8'd1) level_q <= target;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= WIN_C) else $error("window count beyond depth");
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q <= LAST_SLOT) else $error("write slot beyond depth");
	a_ins_med: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_INS |=> state_q == S_MED0 && cnt_q != '0)
		else $error("insert not followed by median read");
	a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MED0 && cnt_q >= CW'(2)) |-> sorted_q[0] <= sorted_q[(WINDOW > 1) ? 1 : 0])
		else $error("sorted cells out of order");

endmodule

>>> sv/ambient_light_brightness_control.sv
// ---------------------------------------------------------------------------
// ambient_light_brightness_control
// clamps light samples, takes a running median and maps it to led brightness
// ---------------------------------------------------------------------------
// a word passes the back-end sequencer states in order: delete (full window only),
// insert, two median reads, multiply, the two-bit-per-cycle divider and the
// final load of the output register, which waits while the last result is not taken
// the back end handles one word at a time
// the two-word queue lets samples be taken while the back end is busy
// reset: arst_n clears the window count, write slot, brightness and queues;
// configuration returns to its reset values, window contents are not cleared
module ambient_light_brightness_control #(
	parameter int WINDOW      = 10,
	parameter int SAMPLE_BITS = 10
) (
	input  logic           clk,
	input  logic           arst_n,
	alb_cfg_if.sink        cfg,
	alb_stream_if.sink     smp,
	alb_result_if.source   res
);
	import alb_pkg::*;

	// configuration registers
	logic [SAMPLE_BITS-1:0] dark_limit_q;
	logic [SAMPLE_BITS-1:0] bright_limit_q;
	level_t                 level_dark_q;
	level_t                 level_bright_q;

	// writes are always taken, out-of-range indexes fall through
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dark_limit_q   <= RST_SENSOR_DARK[SAMPLE_BITS-1:0];
			bright_limit_q <= RST_SENSOR_BRIGHT[SAMPLE_BITS-1:0];
			level_dark_q   <= RST_LEVEL_DARK;
			level_bright_q <= RST_LEVEL_BRIGHT;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_SENSOR_DARK:   dark_limit_q   <= cfg.data[SAMPLE_BITS-1:0];
				REG_SENSOR_BRIGHT: bright_limit_q <= cfg.data[SAMPLE_BITS-1:0];
				REG_LEVEL_DARK:    level_dark_q   <= cfg.data[LEVEL_BITS-1:0];
				REG_LEVEL_BRIGHT:  level_bright_q <= cfg.data[LEVEL_BITS-1:0];
				default: ;
			endcase
		end
	end

	// clamped words between front and back
	alb_stream_if #(.W(SAMPLE_BITS)) q_if ();

	// front: clamp and queue
	alb_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.dark_limit   (dark_limit_q),
		.bright_limit (bright_limit_q),
		.smp          (smp),
		.q            (q_if.source)
	);

	// back: window, median, map, dead band, output register
	alb_back #(.WINDOW(WINDOW), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.dark_limit   (dark_limit_q),
		.bright_limit (bright_limit_q),
		.level_dark   (level_dark_q),
		.level_bright (level_bright_q),
		.q            (q_if.sink),
		.res          (res)
	);

endmodule
